FILE: hdl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared widths, register indexes and reset values for the mecanum mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

  localparam int SPEED_WIDTH_DEF = 16;
  localparam int NUM_WHEELS      = 4;

  localparam int BASE_W       = 16;
  localparam int OFFSET_W     = 16;
  localparam int RATIO_W      = 18;
  localparam int SCALE_W      = 24;
  localparam int SCALE_HALF_W = 12;
  localparam int LIMIT_W      = 15;
  localparam int FRAC_W       = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO_BASE = 3'd0,
    CFG_OFFSET_X   = 3'd1,
    CFG_OFFSET_Y   = 3'd2,
    CFG_RPM_SCALE  = 3'd3,
    CFG_WHEEL_LIM  = 3'd4,
    CFG_VX_LIM     = 3'd5,
    CFG_VY_LIM     = 3'd6,
    CFG_VW_LIM     = 3'd7
  } cfg_idx_t;

  localparam logic [BASE_W-1:0]   RST_RATIO_BASE = 16'd1792;
  localparam logic [OFFSET_W-1:0] RST_OFFSET     = 16'd0;
  localparam logic [SCALE_W-1:0]  RST_RPM_SCALE  = 24'd110000;
  localparam logic [LIMIT_W-1:0]  RST_WHEEL_LIM  = 15'd8500;
  localparam logic [LIMIT_W-1:0]  RST_VXY_LIM    = 15'd3500;
  localparam logic [LIMIT_W-1:0]  RST_VW_LIM     = 15'd300;

endpackage

FILE: hdl/mecanum_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer
// Clamps a chassis velocity request and mixes it into four wheel speeds.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless out_tready holds the pipeline; 9
// arithmetic stages, a 15-stage divider (one quotient bit per stage) and an
// output register, with bubbles collapsed under back-pressure.
// Reset (rst_n low, synchronous): clears all stage valid bits and loads the
// configuration registers with their default values.
module mecanum_wheel_speed_mixer import mwm_pkg::*; #(
  parameter  int SPEED_WIDTH = SPEED_WIDTH_DEF,
  localparam int IN_W        = ((3 * SPEED_WIDTH + 7) / 8) * 8,
  localparam int OUT_W       = ((NUM_WHEELS * SPEED_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // speed_x, speed_y, speed_rot, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // wheel0_rpm .. wheel3_rpm, zero pad
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW      = SPEED_WIDTH;
  localparam int CW      = ((SW > 16) ? SW : 16) + 1;
  localparam int LIN_W   = SW + 2;
  localparam int M_W     = SW + RATIO_W;
  localparam int SUM_W   = SW + 19;
  localparam int PP_W    = SUM_W + SCALE_HALF_W + 1;
  localparam int PROD_W  = SUM_W + SCALE_W + 1;
  localparam int QR_W    = PROD_W - FRAC_W;
  localparam int MAG_W   = SW - 1;
  localparam int NUM_W   = MAG_W + LIMIT_W;
  localparam int MX_CW   = (MAG_W > LIMIT_W) ? MAG_W : LIMIT_W;
  localparam int TOP_ST  = 9;
  localparam int NV      = TOP_ST + LIMIT_W + 1;
  localparam logic signed [QR_W-1:0] TOP_Q = QR_W'(2 ** (SW - 1) - 1);

  // configuration
  logic [BASE_W-1:0]          ratio_base_r;
  logic signed [OFFSET_W-1:0] offset_x_r;
  logic signed [OFFSET_W-1:0] offset_y_r;
  logic [SCALE_W-1:0]         rpm_scale_r;
  logic [LIMIT_W-1:0]         wheel_lim_r;
  logic [LIMIT_W-1:0]         vx_lim_r;
  logic [LIMIT_W-1:0]         vy_lim_r;
  logic [LIMIT_W-1:0]         vw_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_base_r <= RST_RATIO_BASE;
      offset_x_r   <= RST_OFFSET;
      offset_y_r   <= RST_OFFSET;
      rpm_scale_r  <= RST_RPM_SCALE;
      wheel_lim_r  <= RST_WHEEL_LIM;
      vx_lim_r     <= RST_VXY_LIM;
      vy_lim_r     <= RST_VXY_LIM;
      vw_lim_r     <= RST_VW_LIM;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RATIO_BASE: ratio_base_r <= cfg_wdata[BASE_W-1:0];
        CFG_OFFSET_X:   offset_x_r   <= $signed(cfg_wdata[OFFSET_W-1:0]);
        CFG_OFFSET_Y:   offset_y_r   <= $signed(cfg_wdata[OFFSET_W-1:0]);
        CFG_RPM_SCALE:  rpm_scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_WHEEL_LIM:  wheel_lim_r  <= cfg_wdata[LIMIT_W-1:0];
        CFG_VX_LIM:     vx_lim_r     <= cfg_wdata[LIMIT_W-1:0];
        CFG_VY_LIM:     vy_lim_r     <= cfg_wdata[LIMIT_W-1:0];
        CFG_VW_LIM:     vw_lim_r     <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and bubble-collapsing enables
  logic [NV-1:0] v_r;
  logic [NV-1:0] v_nxt;
  logic [NV-1:0] en;

  always_comb begin
    en[NV-1] = !v_r[NV-1] || out_tready;
    for (int k = NV - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < NV; k++) begin
      if (!en[k]) begin
        v_nxt[k] = v_r[k];
      end else if (k == 0) begin
        v_nxt[k] = in_tvalid;
      end else begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NV-1];

  function automatic logic signed [SW-1:0] clamp_mag(input logic signed [SW-1:0] v,
                                                      input logic [LIMIT_W-1:0] lim);
    logic signed [CW-1:0] ve;
    logic signed [CW-1:0] le;
    ve = CW'(v);
    le = $signed(CW'(lim));
    if (ve > le) begin
      clamp_mag = SW'(le);
    end else if (ve < -le) begin
      clamp_mag = SW'(-le);
    end else begin
      clamp_mag = v;
    end
  endfunction

  // stage 0: clamp, per-wheel rotation ratios
  logic signed [SW-1:0]      vx_r, vy_r, vw_r;
  logic signed [RATIO_W-1:0] ratio_r [NUM_WHEELS];
  logic signed [RATIO_W-1:0] base_e, ox_e, oy_e;

  assign base_e = $signed(RATIO_W'(ratio_base_r));
  assign ox_e   = RATIO_W'(offset_x_r);
  assign oy_e   = RATIO_W'(offset_y_r);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vx_r       <= clamp_mag($signed(in_tdata[0*SW +: SW]), vx_lim_r);
      vy_r       <= clamp_mag($signed(in_tdata[1*SW +: SW]), vy_lim_r);
      vw_r       <= clamp_mag($signed(in_tdata[2*SW +: SW]), vw_lim_r);
      ratio_r[0] <= base_e - ox_e + oy_e;
      ratio_r[1] <= base_e - ox_e - oy_e;
      ratio_r[2] <= base_e + ox_e + oy_e;
      ratio_r[3] <= base_e + ox_e - oy_e;
    end
  end

  // stage 1: linear terms, rotation products
  logic signed [LIN_W-1:0] lin_r [NUM_WHEELS];
  logic signed [M_W-1:0]   rot_r [NUM_WHEELS];
  logic signed [LIN_W-1:0] vx_e, vy_e;

  assign vx_e = LIN_W'(vx_r);
  assign vy_e = LIN_W'(vy_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lin_r[0] <= -vx_e - vy_e;
      lin_r[1] <=  vx_e - vy_e;
      lin_r[2] <= -vx_e + vy_e;
      lin_r[3] <=  vx_e + vy_e;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        rot_r[i] <= vw_r * ratio_r[i];
      end
    end
  end

  // stage 2: Q.8 wheel sum
  logic signed [SUM_W-1:0] sum_r [NUM_WHEELS];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        sum_r[i] <= (SUM_W'(lin_r[i]) <<< 8) + SUM_W'(rot_r[i]);
      end
    end
  end

  // stage 3: partial products with the rpm scale halves
  logic signed [PP_W-1:0]           plo_r [NUM_WHEELS];
  logic signed [PP_W-1:0]           phi_r [NUM_WHEELS];
  logic signed [SCALE_HALF_W:0]     scale_lo, scale_hi;

  assign scale_lo = $signed({1'b0, rpm_scale_r[SCALE_HALF_W-1:0]});
  assign scale_hi = $signed({1'b0, rpm_scale_r[SCALE_W-1:SCALE_HALF_W]});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        plo_r[i] <= sum_r[i] * scale_lo;
        phi_r[i] <= sum_r[i] * scale_hi;
      end
    end
  end

  // stage 4: full product
  logic signed [PROD_W-1:0] prod_r [NUM_WHEELS];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        prod_r[i] <= (PROD_W'(phi_r[i]) <<< SCALE_HALF_W) + PROD_W'(plo_r[i]);
      end
    end
  end

  // stage 5: truncate toward zero, saturate
  logic signed [SW-1:0]   w5_r [NUM_WHEELS];
  logic signed [QR_W-1:0] qv_c [NUM_WHEELS];

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      qv_c[i] = $signed(prod_r[i][PROD_W-1:FRAC_W])
              + $signed({{(QR_W-1){1'b0}},
                         prod_r[i][PROD_W-1] && (|prod_r[i][FRAC_W-1:0])});
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (qv_c[i] > TOP_Q) begin
          w5_r[i] <= SW'(TOP_Q);
        end else if (qv_c[i] < -TOP_Q) begin
          w5_r[i] <= SW'(-TOP_Q);
        end else begin
          w5_r[i] <= SW'(qv_c[i]);
        end
      end
    end
  end

  // stage 6: magnitudes
  logic signed [SW-1:0] w6_r   [NUM_WHEELS];
  logic [MAG_W-1:0]     mag6_r [NUM_WHEELS];
  logic signed [SW-1:0] abs_c  [NUM_WHEELS];

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      abs_c[i] = w5_r[i][SW-1] ? -w5_r[i] : w5_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        w6_r[i]   <= w5_r[i];
        mag6_r[i] <= abs_c[i][MAG_W-1:0];
      end
    end
  end

  // stage 7: largest magnitude
  logic signed [SW-1:0] w7_r   [NUM_WHEELS];
  logic [MAG_W-1:0]     mag7_r [NUM_WHEELS];
  logic [MAG_W-1:0]     mx7_r;
  logic [MAG_W-1:0]     m01_c, m23_c;

  assign m01_c = (mag6_r[0] > mag6_r[1]) ? mag6_r[0] : mag6_r[1];
  assign m23_c = (mag6_r[2] > mag6_r[3]) ? mag6_r[2] : mag6_r[3];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      w7_r   <= w6_r;
      mag7_r <= mag6_r;
      mx7_r  <= (m01_c > m23_c) ? m01_c : m23_c;
    end
  end

  // stage 8: dividend, scale decision
  logic signed [SW-1:0] w8_r   [NUM_WHEELS];
  logic [NUM_W-1:0]     num8_r [NUM_WHEELS];
  logic [MAG_W-1:0]     mx8_r;
  logic                 sel8_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      w8_r   <= w7_r;
      mx8_r  <= mx7_r;
      sel8_r <= MX_CW'(mx7_r) > MX_CW'(wheel_lim_r);
      for (int i = 0; i < NUM_WHEELS; i++) begin
        num8_r[i] <= mag7_r[i] * wheel_lim_r;
      end
    end
  end

  // stages 9 .. 23: dividers
  logic signed [SW-1:0] res_c [NUM_WHEELS];

  for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_div
    mwm_div #(
      .SPEED_WIDTH (SPEED_WIDTH)
    ) u_div (
      .clk   (clk),
      .en    (en[TOP_ST +: LIMIT_W]),
      .num   (num8_r[g]),
      .den   (mx8_r),
      .sel   (sel8_r),
      .wheel (w8_r[g]),
      .res   (res_c[g])
    );
  end

  // output register
  logic [OUT_W-1:0] out_tdata_r;
  logic [OUT_W-1:0] out_tdata_nxt;

  always_comb begin
    out_tdata_nxt = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      out_tdata_nxt[i*SW +: SW] = res_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NV-1]) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

FILE: hdl/mwm_div.sv
// ----------------------------------------------------------------------------
// mwm_div
// Pipelined restoring divider for the proportional wheel-speed scaling.
// ----------------------------------------------------------------------------
module mwm_div import mwm_pkg::*; #(
  parameter  int SPEED_WIDTH = SPEED_WIDTH_DEF,
  localparam int MAG_W       = SPEED_WIDTH - 1,
  localparam int NUM_W       = MAG_W + LIMIT_W
) (
  input  logic                          clk,
  input  logic [LIMIT_W-1:0]            en,
  input  logic [NUM_W-1:0]              num,
  input  logic [MAG_W-1:0]              den,
  input  logic                          sel,
  input  logic signed [SPEED_WIDTH-1:0] wheel,
  output logic signed [SPEED_WIDTH-1:0] res
);

  localparam int SW = SPEED_WIDTH;
  localparam int QW = LIMIT_W;

  logic [MAG_W-1:0]     rem_r [QW];
  logic [QW-1:0]        lo_r  [QW];
  logic [QW-1:0]        q_r   [QW];
  logic [MAG_W-1:0]     den_r [QW];
  logic                 sel_r [QW];
  logic signed [SW-1:0] w_r   [QW];

  logic [MAG_W-1:0]     rem_p [QW];
  logic [QW-1:0]        lo_p  [QW];
  logic [QW-1:0]        q_p   [QW];
  logic [MAG_W-1:0]     den_p [QW];
  logic                 sel_p [QW];
  logic signed [SW-1:0] w_p   [QW];
  logic [SW-1:0]        t_c   [QW];
  logic [SW-1:0]        d_c   [QW];
  logic                 ge_c  [QW];

  logic signed [SW-1:0] q_ext;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_p[k] = num[NUM_W-1:QW];
        lo_p[k]  = num[QW-1:0];
        q_p[k]   = '0;
        den_p[k] = den;
        sel_p[k] = sel;
        w_p[k]   = wheel;
      end else begin
        rem_p[k] = rem_r[k-1];
        lo_p[k]  = lo_r[k-1];
        q_p[k]   = q_r[k-1];
        den_p[k] = den_r[k-1];
        sel_p[k] = sel_r[k-1];
        w_p[k]   = w_r[k-1];
      end
      t_c[k]  = {rem_p[k], lo_p[k][QW-1]};
      ge_c[k] = t_c[k] >= {1'b0, den_p[k]};
      d_c[k]  = t_c[k] - {1'b0, den_p[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (en[k]) begin
        rem_r[k] <= ge_c[k] ? d_c[k][MAG_W-1:0] : t_c[k][MAG_W-1:0];
        lo_r[k]  <= {lo_p[k][QW-2:0], 1'b0};
        q_r[k]   <= {q_p[k][QW-2:0], ge_c[k]};
        den_r[k] <= den_p[k];
        sel_r[k] <= sel_p[k];
        w_r[k]   <= w_p[k];
      end
    end
  end

  assign q_ext = $signed(SW'(q_r[QW-1]));

  always_comb begin
    if (!sel_r[QW-1]) begin
      res = w_r[QW-1];
    end else if (w_r[QW-1][SW-1]) begin
      res = -q_ext;
    end else begin
      res = q_ext;
    end
  end

endmodule

FILE: hdl/mwm_checker.sv
// ----------------------------------------------------------------------------
// mwm_checker
// Port-level checks for the mecanum mixer result stream.
// ----------------------------------------------------------------------------
module mwm_checker import mwm_pkg::*; #(
  parameter  int SPEED_WIDTH = SPEED_WIDTH_DEF,
  localparam int OUT_W       = ((NUM_WHEELS * SPEED_WIDTH + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int SW = SPEED_WIDTH;

  logic has_min;
  logic pad_set;

  always_comb begin
    has_min = 1'b0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (out_tdata[i*SW +: SW] == {1'b1, {(SW-1){1'b0}}}) begin
        has_min = 1'b1;
      end
    end
    pad_set = |(out_tdata >> (NUM_WHEELS * SW));
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("request dropped under back-pressure");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !has_min)
    else $error("wheel speed outside the saturation range");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !pad_set)
    else $error("nonzero pad bits in out_tdata");

endmodule

bind mecanum_wheel_speed_mixer mwm_checker #(
  .SPEED_WIDTH (SPEED_WIDTH)
) u_mwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
